// File: rtl/dsep_pkg.sv
// Shared types, constants and calendar helpers for the date string to epoch seconds unit.
package dsep_pkg;

  // Character positions in "YYYYMMDD HH:MM:SS"
  localparam logic [4:0] POS_YEAR_END   = 5'd3;
  localparam logic [4:0] POS_MONTH_END  = 5'd5;
  localparam logic [4:0] POS_DAY_END    = 5'd7;
  localparam logic [4:0] POS_SEP_DATE   = 5'd8;
  localparam logic [4:0] POS_HOUR_END   = 5'd10;
  localparam logic [4:0] POS_SEP_HM     = 5'd11;
  localparam logic [4:0] POS_MINUTE_END = 5'd13;
  localparam logic [4:0] POS_SEP_MS     = 5'd14;
  localparam logic [4:0] POS_LAST_DIGIT = 5'd16;
  localparam logic [4:0] POS_SAT        = 5'd18;
  localparam logic [4:0] POS_SHORT_LAST = 5'd7;
  localparam logic [4:0] POS_LONG_LAST  = 5'd16;

  localparam logic [13:0] EPOCH_YEAR     = 14'd1970;
  localparam logic [11:0] LEAPS_TO_EPOCH = 12'd477;   // leap years in 1..1969
  localparam logic [21:0] DAYS_PER_YEAR  = 22'd365;
  localparam logic [38:0] SECS_PER_DAY   = 39'd86400;
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN   = 17'd60;

  // floor(n / 100) = (n * RECIP100) >> RECIP100_SHIFT for every 14-bit n
  localparam logic [26:0] RECIP100       = 27'd5243;
  localparam int          RECIP100_SHIFT = 19;

  // n is a multiple of 25 iff (n * INV25) mod 2^14 <= INV25_LIM
  localparam logic [27:0] INV25     = 28'd7209;
  localparam logic [13:0] INV25_LIM = 14'd655;

  typedef struct packed {
    logic        len_ok;
    logic        bad;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic div25(input logic [13:0] n);
    logic [27:0] p;
    p = {14'd0, n} * INV25;
    return p[13:0] <= INV25_LIM;
  endfunction

endpackage

// File: rtl/dsep_calc.sv
// Check and epoch conversion pipeline: field register, three compute stages, result register.
module dsep_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fld_valid,
  output logic              fld_ready,
  input  dsep_pkg::fields_t fld,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_valid_res,
  output logic [13:0]       out_year_out,
  output logic [3:0]        out_month_out,
  output logic [4:0]        out_day_out,
  output logic [4:0]        out_hour_out,
  output logic [5:0]        out_minute_out,
  output logic [5:0]        out_second_out,
  output logic [37:0]       out_epoch_seconds
);

  logic adv1, adv2, adv3, advo;
  logic v1_r, v2_r, v3_r, vo_r;

  // stage 1: parsed fields
  dsep_pkg::fields_t f1_r;

  // stage 2: checked fields and day pieces
  logic        ok2_r;
  logic [13:0] yr2_r;
  logic [3:0]  mo2_r;
  logic [4:0]  dy2_r, hr2_r;
  logic [5:0]  mi2_r, se2_r;
  logic [12:0] yoff2_r;
  logic [11:0] leaps2_r;
  logic [8:0]  doy2_r;

  // stage 3: day count and time of day
  logic        ok3_r;
  logic [13:0] yr3_r;
  logic [3:0]  mo3_r;
  logic [4:0]  dy3_r, hr3_r;
  logic [5:0]  mi3_r, se3_r;
  logic [21:0] days3_r;
  logic [16:0] hms3_r;

  // result register
  logic        oko_r;
  logic [13:0] yro_r;
  logic [3:0]  moo_r;
  logic [4:0]  dyo_r, hro_r;
  logic [5:0]  mio_r, seo_r;
  logic [37:0] epo_r;

  // stage 1 logic
  logic        leap, is25, feb_extra, ok1;
  logic [4:0]  mlen;
  logic [13:0] ym1;
  logic [26:0] q100_prod;
  logic [7:0]  q100;
  logic [11:0] leaps;
  logic [8:0]  doy;

  // stage 2 and 3 logic
  logic [21:0] days;
  logic [16:0] hms;
  logic [38:0] secs;

  assign advo      = !vo_r || out_ready;
  assign adv3      = !v3_r || advo;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign fld_ready = adv1;

  always_comb begin
    is25      = dsep_pkg::div25(f1_r.year);
    leap      = (f1_r.year[1:0] == 2'd0 && !is25) || (f1_r.year[3:0] == 4'd0 && is25);
    feb_extra = (f1_r.month == 7'd2) && leap;
    mlen      = dsep_pkg::month_len(f1_r.month[3:0]) + {4'd0, feb_extra};
    ok1 = f1_r.len_ok && !f1_r.bad && (f1_r.year >= dsep_pkg::EPOCH_YEAR) &&
          (f1_r.month >= 7'd1) && (f1_r.month <= 7'd12) &&
          (f1_r.day >= 7'd1) && (f1_r.day <= {2'd0, mlen}) &&
          (f1_r.hour <= 7'd23) && (f1_r.minute <= 7'd59) && (f1_r.second <= 7'd59);
    // leap years in 1..year-1 minus those before the epoch
    ym1       = f1_r.year - 14'd1;
    q100_prod = {13'd0, ym1} * dsep_pkg::RECIP100;
    q100      = q100_prod[dsep_pkg::RECIP100_SHIFT +: 8];
    leaps     = ym1[13:2] - {4'd0, q100} + {6'd0, q100[7:2]} - dsep_pkg::LEAPS_TO_EPOCH;
    doy       = dsep_pkg::days_before(f1_r.month[3:0]) +
                {8'd0, (f1_r.month > 7'd2) && leap} + {2'd0, f1_r.day} - 9'd1;
  end

  always_comb begin
    days = {9'd0, yoff2_r} * dsep_pkg::DAYS_PER_YEAR + {10'd0, leaps2_r} + {13'd0, doy2_r};
    hms  = {12'd0, hr2_r} * dsep_pkg::SECS_PER_HOUR + {11'd0, mi2_r} * dsep_pkg::SECS_PER_MIN +
           {11'd0, se2_r};
    secs = {17'd0, days3_r} * dsep_pkg::SECS_PER_DAY + {22'd0, hms3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= fld_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (advo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) f1_r <= fld;
    if (adv2) begin
      // drop every field of an invalid word
      ok2_r    <= ok1;
      yr2_r    <= ok1 ? f1_r.year : 14'd0;
      mo2_r    <= ok1 ? f1_r.month[3:0] : 4'd0;
      dy2_r    <= ok1 ? f1_r.day[4:0] : 5'd0;
      hr2_r    <= ok1 ? f1_r.hour[4:0] : 5'd0;
      mi2_r    <= ok1 ? f1_r.minute[5:0] : 6'd0;
      se2_r    <= ok1 ? f1_r.second[5:0] : 6'd0;
      yoff2_r  <= 13'(f1_r.year - dsep_pkg::EPOCH_YEAR);
      leaps2_r <= leaps;
      doy2_r   <= doy;
    end
    if (adv3) begin
      ok3_r   <= ok2_r;
      yr3_r   <= yr2_r;
      mo3_r   <= mo2_r;
      dy3_r   <= dy2_r;
      hr3_r   <= hr2_r;
      mi3_r   <= mi2_r;
      se3_r   <= se2_r;
      days3_r <= days;
      hms3_r  <= hms;
    end
    if (advo) begin
      oko_r <= ok3_r;
      yro_r <= yr3_r;
      moo_r <= mo3_r;
      dyo_r <= dy3_r;
      hro_r <= hr3_r;
      mio_r <= mi3_r;
      seo_r <= se3_r;
      epo_r <= ok3_r ? secs[37:0] : 38'd0;
    end
  end

  assign out_valid         = vo_r;
  assign out_valid_res     = oko_r;
  assign out_year_out      = yro_r;
  assign out_month_out     = moo_r;
  assign out_day_out       = dyo_r;
  assign out_hour_out      = hro_r;
  assign out_minute_out    = mio_r;
  assign out_second_out    = seo_r;
  assign out_epoch_seconds = epo_r;

endmodule

// File: rtl/date_string_to_epoch_seconds_unit.sv
// Top level: character scanner with digit accumulators, feeding the conversion pipeline.
//
//   channel | handshake           | payload
//   in_     | in_valid / in_ready  | in_char_in[7:0], in_is_last
//   out_    | out_valid / out_ready| out_valid_res, out_year_out .. out_epoch_seconds[37:0]
//
// One character is taken per cycle while in_ready is high; characters without the last
// marker give no word. After its last character is taken, a word passes through four
// registers (fields, checks, day count, result) on its way to the output.
// Synchronous active-low reset clears the scanner position, accumulators and valid bits.
// A stalled output holds the pipeline; in_ready drops only once every stage is full.
module date_string_to_epoch_seconds_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [13:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic [37:0] out_epoch_seconds
);

  logic [4:0]  pos_r, pos_nxt, pos_upd;
  logic [13:0] year_r, year_nxt, year_upd;
  logic [6:0]  month_r, month_nxt, month_upd;
  logic [6:0]  day_r, day_nxt, day_upd;
  logic [6:0]  hour_r, hour_nxt, hour_upd;
  logic [6:0]  minute_r, minute_nxt, minute_upd;
  logic [6:0]  second_r, second_nxt, second_upd;
  logic        bad_r, bad_nxt, bad_upd;

  logic        accept, is_digit, digit_pos, fld_ready;
  logic [3:0]  dval;
  logic [17:0] year_mac;
  logic [10:0] month_mac, day_mac, hour_mac, minute_mac, second_mac;
  dsep_pkg::fields_t fld;

  assign accept = in_valid && in_ready;
  assign in_ready = fld_ready;

  always_comb begin
    is_digit  = (in_char_in >= 8'h30) && (in_char_in <= 8'h39);
    dval      = is_digit ? in_char_in[3:0] : 4'd0;
    digit_pos = (pos_r <= dsep_pkg::POS_LAST_DIGIT) && (pos_r != dsep_pkg::POS_SEP_DATE) &&
                (pos_r != dsep_pkg::POS_SEP_HM) && (pos_r != dsep_pkg::POS_SEP_MS);

    year_mac   = {4'd0, year_r} * 18'd10 + {14'd0, dval};
    month_mac  = {4'd0, month_r} * 11'd10 + {7'd0, dval};
    day_mac    = {4'd0, day_r} * 11'd10 + {7'd0, dval};
    hour_mac   = {4'd0, hour_r} * 11'd10 + {7'd0, dval};
    minute_mac = {4'd0, minute_r} * 11'd10 + {7'd0, dval};
    second_mac = {4'd0, second_r} * 11'd10 + {7'd0, dval};

    year_upd   = year_r;
    month_upd  = month_r;
    day_upd    = day_r;
    hour_upd   = hour_r;
    minute_upd = minute_r;
    second_upd = second_r;
    bad_upd    = bad_r;
    if (digit_pos) begin
      bad_upd = bad_r || !is_digit;
      if (pos_r <= dsep_pkg::POS_YEAR_END) begin
        year_upd = year_mac[13:0];
      end else if (pos_r <= dsep_pkg::POS_MONTH_END) begin
        month_upd = month_mac[6:0];
      end else if (pos_r <= dsep_pkg::POS_DAY_END) begin
        day_upd = day_mac[6:0];
      end else if (pos_r <= dsep_pkg::POS_HOUR_END) begin
        hour_upd = hour_mac[6:0];
      end else if (pos_r <= dsep_pkg::POS_MINUTE_END) begin
        minute_upd = minute_mac[6:0];
      end else begin
        second_upd = second_mac[6:0];
      end
    end
    pos_upd = (pos_r < dsep_pkg::POS_SAT) ? pos_r + 5'd1 : pos_r;

    fld.len_ok = (pos_r == dsep_pkg::POS_SHORT_LAST) || (pos_r == dsep_pkg::POS_LONG_LAST);
    fld.bad    = bad_upd;
    fld.year   = year_upd;
    fld.month  = month_upd;
    fld.day    = day_upd;
    fld.hour   = hour_upd;
    fld.minute = minute_upd;
    fld.second = second_upd;

    pos_nxt    = pos_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    bad_nxt    = bad_r;
    if (accept) begin
      if (in_is_last) begin
        // word complete: start a fresh string
        pos_nxt    = 5'd0;
        year_nxt   = 14'd0;
        month_nxt  = 7'd0;
        day_nxt    = 7'd0;
        hour_nxt   = 7'd0;
        minute_nxt = 7'd0;
        second_nxt = 7'd0;
        bad_nxt    = 1'b0;
      end else begin
        pos_nxt    = pos_upd;
        year_nxt   = year_upd;
        month_nxt  = month_upd;
        day_nxt    = day_upd;
        hour_nxt   = hour_upd;
        minute_nxt = minute_upd;
        second_nxt = second_upd;
        bad_nxt    = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 5'd0;
      year_r   <= 14'd0;
      month_r  <= 7'd0;
      day_r    <= 7'd0;
      hour_r   <= 7'd0;
      minute_r <= 7'd0;
      second_r <= 7'd0;
      bad_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      bad_r    <= bad_nxt;
    end
  end

  dsep_calc u_calc (
    .clk               (clk),
    .rst_n             (rst_n),
    .fld_valid         (accept && in_is_last),
    .fld_ready         (fld_ready),
    .fld               (fld),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_valid_res     (out_valid_res),
    .out_year_out      (out_year_out),
    .out_month_out     (out_month_out),
    .out_day_out       (out_day_out),
    .out_hour_out      (out_hour_out),
    .out_minute_out    (out_minute_out),
    .out_second_out    (out_second_out),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule

// File: tb/tb_date_string_to_epoch_seconds_unit.sv
// Self-checking testbench for the date string to epoch seconds unit, driven with directed and random strings.
module tb_date_string_to_epoch_seconds_unit;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_CHARS = 600;

  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [37:0] secs;
  } date_word_t;

  typedef byte unsigned text_t[$];

  class epoch_scoreboard;
    date_word_t  expected_dates[$];
    int          errors;
    int unsigned month_days[13];
    int unsigned days_ahead[13];
    logic [4:0]  pos;
    logic [13:0] yr;
    logic [6:0]  mo, dy, hr, mi, se;
    logic        bad;

    function new();
      errors     = 0;
      month_days = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      days_ahead = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      clear();
    endfunction

    function void clear();
      pos = '0;
      yr  = '0;
      mo  = '0;
      dy  = '0;
      hr  = '0;
      mi  = '0;
      se  = '0;
      bad = 1'b0;
    endfunction

    function bit leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned leaps_upto(int unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    // Advance the string state by one accepted character; queue a result on the last one.
    function void note_char(logic [7:0] c, logic last);
      date_word_t      w;
      logic            dig;
      int unsigned     d;
      int unsigned     ml;
      int unsigned     yv;
      bit              ok;
      longint unsigned days;
      dig = (c >= 8'h30) && (c <= 8'h39);
      d   = dig ? {28'd0, c[3:0]} : 32'd0;
      if (pos <= 16 && pos != 8 && pos != 11 && pos != 14) begin
        if (!dig) bad = 1'b1;
        if (pos <= 3) yr = 14'({18'd0, yr} * 32'd10 + d);
        else if (pos <= 5) mo = 7'({25'd0, mo} * 32'd10 + d);
        else if (pos <= 7) dy = 7'({25'd0, dy} * 32'd10 + d);
        else if (pos <= 10) hr = 7'({25'd0, hr} * 32'd10 + d);
        else if (pos <= 13) mi = 7'({25'd0, mi} * 32'd10 + d);
        else se = 7'({25'd0, se} * 32'd10 + d);
      end
      if (pos < 18) pos = pos + 5'd1;
      if (!last) return;
      // pos now holds the length, or 18 once saturated
      yv = {18'd0, yr};
      ok = (pos == 8 || pos == 17) && !bad;
      ok = ok && yr >= 1970 && mo >= 1 && mo <= 12;
      if (ok) begin
        ml = month_days[mo[3:0]] + ((mo == 2 && leap(yv)) ? 32'd1 : 32'd0);
        ok = dy >= 1 && dy <= ml;
      end
      ok = ok && hr <= 23 && mi <= 59 && se <= 59;
      w = '0;
      if (ok) begin
        days = {32'd0, days_ahead[mo[3:0]]};
        if (mo > 2 && leap(yv)) days = days + 64'd1;
        days = days + {32'd0, yv - 32'd1970} * 64'd365;
        days = days + {32'd0, leaps_upto(yv - 32'd1)} - {32'd0, leaps_upto(32'd1969)};
        days = days + {57'd0, dy} - 64'd1;
        w.valid  = 1'b1;
        w.year   = yr;
        w.month  = mo[3:0];
        w.day    = dy[4:0];
        w.hour   = hr[4:0];
        w.minute = mi[5:0];
        w.second = se[5:0];
        w.secs   = 38'(days * 64'd86400 + {57'd0, hr} * 64'd3600 + {57'd0, mi} * 64'd60 +
                       {57'd0, se});
      end
      expected_dates.push_back(w);
      clear();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task cmp_field(string name, logic [37:0] got, logic [37:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_word(date_word_t got);
      date_word_t w;
      if (expected_dates.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      w = expected_dates.pop_front();
      cmp_field("valid", {37'd0, got.valid}, {37'd0, w.valid});
      cmp_field("year", {24'd0, got.year}, {24'd0, w.year});
      cmp_field("month", {34'd0, got.month}, {34'd0, w.month});
      cmp_field("day", {33'd0, got.day}, {33'd0, w.day});
      cmp_field("hour", {33'd0, got.hour}, {33'd0, w.hour});
      cmp_field("minute", {32'd0, got.minute}, {32'd0, w.minute});
      cmp_field("second", {32'd0, got.second}, {32'd0, w.second});
      cmp_field("epoch", got.secs, w.secs);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_valid_res;
  logic [13:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;
  logic [37:0] out_epoch_seconds;

  epoch_scoreboard board;
  text_t           line;
  int              chars_sent = 0;
  int              idle_cycles = 0;
  bit              src_burst = 1'b0;
  bit              dst_burst = 1'b0;
  bit              dst_hold = 1'b0;

  date_string_to_epoch_seconds_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_second_out   (out_second_out),
    .out_epoch_seconds(out_epoch_seconds)
  );

  initial board = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are sampled on the same edge the block sees them
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_char(in_char_in, in_is_last);
    if (rst_n && out_valid && out_ready) begin
      board.check_word({out_valid_res, out_year_out, out_month_out, out_day_out,
                        out_hour_out, out_minute_out, out_second_out, out_epoch_seconds});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request
  initial begin
    int gap;
    out_ready <= 1'b0;
    forever begin
      if (dst_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        dst_hold = 1'b0;
      end
      gap = dst_burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task send_char(byte unsigned c, bit last);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task send_line();
    for (int i = 0; i < line.size(); i++) send_char(line[i], i == line.size() - 1);
  endtask

  // Hold the sender until every queued result has come back
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic void put_num(int unsigned v, int n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div = div * 10;
    repeat (n) begin
      line.push_back(8'h30 + 8'((v / div) % 10));
      div = div / 10;
    end
  endfunction

  function automatic byte unsigned pick_sep(byte unsigned usual);
    return ($urandom_range(0, 99) < 85) ? usual : byte'($urandom_range(0, 255));
  endfunction

  function automatic void build_date(int unsigned y, int unsigned m, int unsigned d,
                                     bit long_form, int unsigned h, int unsigned mn,
                                     int unsigned s);
    line.delete();
    put_num(y, 4);
    put_num(m, 2);
    put_num(d, 2);
    if (long_form) begin
      line.push_back(pick_sep(" "));
      put_num(h, 2);
      line.push_back(pick_sep(":"));
      put_num(mn, 2);
      line.push_back(pick_sep(":"));
      put_num(s, 2);
    end
  endfunction

  function automatic void build_random_date();
    int unsigned y, m, d, h, mn, s;
    case ($urandom_range(0, 9))
      0, 1:    y = $urandom_range(0, 9999);
      2:       y = $urandom_range(1965, 1975);
      default: y = $urandom_range(1970, 2100);
    endcase
    m  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    d  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 31) : $urandom_range(0, 39);
    h  = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 23) : $urandom_range(0, 99);
    mn = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    s  = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    build_date(y, m, d, $urandom_range(0, 1) != 0, h, mn, s);
  endfunction

  initial begin
    int kind;
    int n;
    int start_count;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_char_in <= 8'h00;
    in_is_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: epoch start, top of range, leap rules, free separators, bad digit,
    // over-long string and a one-character string
    build_date(1970, 1, 1, 0, 0, 0, 0);
    send_line();
    line.delete();
    put_num(9999, 4); put_num(1231, 4);
    line.push_back(" "); put_num(23, 2); line.push_back(":"); put_num(59, 2);
    line.push_back(":"); put_num(59, 2);
    send_line();
    build_date(2000, 2, 29, 0, 0, 0, 0);
    send_line();
    build_date(2100, 2, 29, 0, 0, 0, 0);
    send_line();
    build_date(2024, 6, 15, 1, 12, 30, 45);
    line[8]  = 8'h00;
    line[11] = 8'hff;
    line[14] = "x";
    send_line();
    build_date(2024, 6, 15, 0, 0, 0, 0);
    line[4] = 8'h00;
    send_line();
    build_date(2024, 6, 15, 1, 12, 30, 45);
    line.push_back("9");
    line.push_back("9");
    send_line();
    line.delete();
    line.push_back(8'hff);
    send_line();
    wait_drained();

    // Stall the output long enough to fill the block while the sender keeps going
    dst_hold  = 1'b1;
    src_burst = 1'b1;
    repeat (8) begin
      build_date($urandom_range(1970, 2400), $urandom_range(1, 12), $urandom_range(1, 28),
                 0, 0, 0, 0);
      send_line();
    end
    src_burst = 1'b0;
    wait_drained();

    start_count = chars_sent;
    while (chars_sent - start_count < RANDOM_CHARS) begin
      src_burst = ($urandom_range(0, 9) == 0);
      dst_burst = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        build_random_date();
      end else if (kind < 75) begin
        build_random_date();
        line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 85) begin
        build_random_date();
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, line.size() - 1);
          repeat (n) void'(line.pop_back());
        end else begin
          repeat ($urandom_range(1, 6)) line.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
      end else begin
        line.delete();
        n = $urandom_range(1, 24);
        repeat (n) begin
          if ($urandom_range(0, 1)) line.push_back(8'h30 + 8'($urandom_range(0, 9)));
          else line.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_line();
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
    src_burst = 1'b0;
    dst_burst = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dsep_pkg.sv
rtl/dsep_calc.sv
rtl/date_string_to_epoch_seconds_unit.sv
tb/tb_date_string_to_epoch_seconds_unit.sv
